[hw/rtl/pnrd_pkg.sv]
// ----------------------------------------------------------------------------
// pnrd_pkg: shared types and constants
// Opcodes, sequencer state codes, box edge codes and the control structs that
// pass between the rectangle drawer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pnrd_pkg;

   localparam int OP_W    = 3;
   localparam int COORD_W = 10;
   localparam int COLOR_W = 4;
   localparam int TH_W    = 8;
   localparam int BYTE_W  = 8;
   localparam int PHASE_W = 2;

   localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
   localparam logic [OP_W-1:0] OP_READ  = 3'd1;
   localparam logic [OP_W-1:0] OP_HLINE = 3'd2;
   localparam logic [OP_W-1:0] OP_VLINE = 3'd3;
   localparam logic [OP_W-1:0] OP_BOX   = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

   // box edges, drawn in this order
   localparam logic [PHASE_W-1:0] PH_TOP    = 2'd0;
   localparam logic [PHASE_W-1:0] PH_BOTTOM = 2'd1;
   localparam logic [PHASE_W-1:0] PH_LEFT   = 2'd2;
   localparam logic [PHASE_W-1:0] PH_RIGHT  = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SETUP = 7'b0000010,
      ST_BASE  = 7'b0000100,
      ST_RD    = 7'b0001000,
      ST_WR    = 7'b0010000,
      ST_CLEAR = 7'b0100000,
      ST_FIN   = 7'b1000000
   } seq_state_type;

   typedef struct packed {
      logic start;   // item accepted this cycle
      logic ack;     // result register can take the finished item
   } seq_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_stat_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

[hw/rtl/packed_nibble_rect_drawer.sv]
// ----------------------------------------------------------------------------
// packed_nibble_rect_drawer: 4bpp framebuffer drawing engine
// Operation: each drawn pixel is a byte read then a byte write on the single
//   framebuffer port; each rectangle adds a setup and a base step; every item
//   ends in a finish state; a box is four rectangles; spare opcodes only set up
//   and finish; clear writes all ROW_BYTES*FB_HEIGHT bytes.
// Flow: one item at a time; the next item is taken once the result moves
//   to the output register; the next result waits in FIN while that one stalls.
// Reset: synchronous, clears control state and clear_byte; framebuffer undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_nibble_rect_drawer #(
   parameter int FB_WIDTH  = 320,
   parameter int FB_HEIGHT = 240
) (
   input  logic                         clock,
   input  logic                         reset,
   // command items
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pnrd_pkg::OP_W-1:0]    req_opcode,
   input  logic [pnrd_pkg::COORD_W-1:0] req_x_start,
   input  logic [pnrd_pkg::COORD_W-1:0] req_y_start,
   input  logic [pnrd_pkg::COORD_W-1:0] req_x_end,
   input  logic [pnrd_pkg::COORD_W-1:0] req_y_end,
   input  logic [pnrd_pkg::COLOR_W-1:0] req_color,
   input  logic [pnrd_pkg::TH_W-1:0]    req_thickness,
   // result items
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pnrd_pkg::COLOR_W-1:0] rsp_read_pixel,
   output logic                         rsp_done_res,
   // clear byte register
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pnrd_pkg::BYTE_W-1:0]  csr_clear_byte
);

   // Packed layout: two pixels per byte, even x in the high nibble.
   localparam int ROW_BYTES   = (FB_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * FB_HEIGHT;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

   pnrd_pkg::seq_ctl_type  seq_ctl;
   pnrd_pkg::seq_stat_type seq_stat;
   pnrd_pkg::mem_ctl_type  mem_ctl;
   logic [ADDR_W-1:0]             mem_addr;
   logic [pnrd_pkg::BYTE_W-1:0]   mem_wr_data;
   logic [pnrd_pkg::BYTE_W-1:0]   mem_rd_data;
   logic [pnrd_pkg::COLOR_W-1:0]  seq_read_pixel;

   logic [pnrd_pkg::BYTE_W-1:0]  clear_byte_ff, clear_byte_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pnrd_pkg::COLOR_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                         rsp_done_ff, rsp_done_in;
   logic                         rsp_load;

   // Accept a new item whenever the sequencer is idle; a finished result may
   // still be sitting in the output register.
   assign req_stall     = !seq_stat.idle;
   assign seq_ctl.start = req_valid && !req_stall;

   // Output register frees when empty or being taken this cycle.
   assign seq_ctl.ack = !rsp_valid_ff || !rsp_stall;
   assign rsp_load    = seq_stat.done && seq_ctl.ack;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_pixel_in = seq_read_pixel;
         rsp_done_in  = 1'b1;
      end
   end

   // Register is only written between items.
   assign csr_ready     = seq_stat.idle;
   assign clear_byte_in = (csr_valid && csr_ready) ? csr_clear_byte : clear_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         clear_byte_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         clear_byte_ff <= clear_byte_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_pixel = rsp_pixel_ff;
   assign rsp_done_res   = rsp_done_ff;

   // Sequencer: clipping, rectangle walk, read-modify-write, clear sweep.
   pnrd_seq #(
      .FB_WIDTH    (FB_WIDTH),
      .FB_HEIGHT   (FB_HEIGHT),
      .ROW_BYTES   (ROW_BYTES),
      .STORE_BYTES (STORE_BYTES),
      .ADDR_W      (ADDR_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .ctl         (seq_ctl),
      .stat        (seq_stat),
      .opcode      (req_opcode),
      .x_start     (req_x_start),
      .y_start     (req_y_start),
      .x_end       (req_x_end),
      .y_end       (req_y_end),
      .color       (req_color),
      .thickness   (req_thickness),
      .clear_byte  (clear_byte_ff),
      .read_pixel  (seq_read_pixel),
      .mem_ctl     (mem_ctl),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   // Framebuffer: one byte per address, row y at y*ROW_BYTES.
   pnrd_fb_mem #(
      .DEPTH  (STORE_BYTES),
      .ADDR_W (ADDR_W)
   ) u_fb_mem (
      .clock   (clock),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule

[hw/rtl/pnrd_fb_mem.sv]
// ----------------------------------------------------------------------------
// pnrd_fb_mem: framebuffer byte store
// Single-port byte memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pnrd_fb_mem #(
   parameter int DEPTH  = 38400,
   parameter int ADDR_W = 16
) (
   input  logic                        clock,
   input  pnrd_pkg::mem_ctl_type       ctl,
   input  logic [ADDR_W-1:0]           addr,
   input  logic [pnrd_pkg::BYTE_W-1:0] wr_data,
   output logic [pnrd_pkg::BYTE_W-1:0] rd_data
);

   logic [pnrd_pkg::BYTE_W-1:0] store_ff [DEPTH];
   logic [pnrd_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) (ctl.rd_en || ctl.wr_en) |-> (int'(addr) < DEPTH))
      else $error("framebuffer access out of range");
   assert property (@(posedge clock) !(ctl.rd_en && ctl.wr_en))
      else $error("read and write in the same cycle");
`endif

endmodule

[hw/rtl/pnrd_seq.sv]
// ----------------------------------------------------------------------------
// pnrd_seq: command sequencer and pixel walker
// Splits a command into clipped rectangles and walks them one pixel at a time
// with a byte read-modify-write (read only for a pixel read); also runs the clear sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pnrd_seq #(
   parameter int FB_WIDTH    = 320,
   parameter int FB_HEIGHT   = 240,
   parameter int ROW_BYTES   = 160,
   parameter int STORE_BYTES = 38400,
   parameter int ADDR_W      = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pnrd_pkg::seq_ctl_type        ctl,
   output pnrd_pkg::seq_stat_type       stat,
   input  logic [pnrd_pkg::OP_W-1:0]    opcode,
   input  logic [pnrd_pkg::COORD_W-1:0] x_start,
   input  logic [pnrd_pkg::COORD_W-1:0] y_start,
   input  logic [pnrd_pkg::COORD_W-1:0] x_end,
   input  logic [pnrd_pkg::COORD_W-1:0] y_end,
   input  logic [pnrd_pkg::COLOR_W-1:0] color,
   input  logic [pnrd_pkg::TH_W-1:0]    thickness,
   input  logic [pnrd_pkg::BYTE_W-1:0]  clear_byte,
   output logic [pnrd_pkg::COLOR_W-1:0] read_pixel,
   output pnrd_pkg::mem_ctl_type        mem_ctl,
   output logic [ADDR_W-1:0]            mem_addr,
   output logic [pnrd_pkg::BYTE_W-1:0]  mem_wr_data,
   input  logic [pnrd_pkg::BYTE_W-1:0]  mem_rd_data
);

   localparam int CW     = pnrd_pkg::COORD_W;
   localparam int CALC_W = ADDR_W + CW + 1;
   localparam logic [CW:0]   X_LIM     = (CW + 1)'(FB_WIDTH);
   localparam logic [CW:0]   Y_LIM     = (CW + 1)'(FB_HEIGHT);
   localparam logic [CW-1:0] X_MAX     = CW'(FB_WIDTH - 1);
   localparam logic [CW-1:0] Y_MAX     = CW'(FB_HEIGHT - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   pnrd_pkg::seq_state_type state_ff, state_in;
   logic [pnrd_pkg::PHASE_W-1:0] phase_ff, phase_in;

   logic [pnrd_pkg::OP_W-1:0]    op_ff, op_in;
   logic [CW-1:0]                xs_ff, xs_in, ys_ff, ys_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [pnrd_pkg::COLOR_W-1:0] color_ff, color_in;
   logic [pnrd_pkg::TH_W-1:0]    th_ff, th_in;

   logic [CW-1:0]     x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic              empty_ff, empty_in;
   logic [CW-1:0]     cx_ff, cx_in, cy_ff, cy_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic [pnrd_pkg::COLOR_W-1:0] rd_nib_ff, rd_nib_in;

   // rectangle bounds for the current command / box edge
   logic          x0_use_xe, x1_use_xe, x_add_th, y0_use_ye, y1_use_ye, y_add_th;
   logic [CW-1:0] x0_sel, y0_sel;
   logic [CW:0]   x1_raw, y1_raw;
   logic [CW-1:0] x1_clip, y1_clip;

   logic [CALC_W-1:0] pix_sum, base_mul, base_step;
   logic [ADDR_W-1:0] pix_addr;
   logic              last_rect;
   pnrd_pkg::seq_state_type after_rect;

   always_comb begin
      x0_use_xe = 1'b0;
      x1_use_xe = 1'b0;
      x_add_th  = 1'b0;
      y0_use_ye = 1'b0;
      y1_use_ye = 1'b0;
      y_add_th  = 1'b0;
      case (op_ff)
         pnrd_pkg::OP_HLINE: begin
            x1_use_xe = 1'b1;
            y_add_th  = 1'b1;
         end
         pnrd_pkg::OP_VLINE: begin
            x_add_th  = 1'b1;
            y1_use_ye = 1'b1;
         end
         pnrd_pkg::OP_BOX: begin
            case (phase_ff)
               pnrd_pkg::PH_TOP: begin
                  x1_use_xe = 1'b1;
                  y_add_th  = 1'b1;
               end
               pnrd_pkg::PH_BOTTOM: begin
                  x1_use_xe = 1'b1;
                  y0_use_ye = 1'b1;
                  y1_use_ye = 1'b1;
                  y_add_th  = 1'b1;
               end
               pnrd_pkg::PH_LEFT: begin
                  x_add_th  = 1'b1;
                  y1_use_ye = 1'b1;
               end
               default: begin
                  // right edge: one thickness longer at the bottom
                  x0_use_xe = 1'b1;
                  x1_use_xe = 1'b1;
                  x_add_th  = 1'b1;
                  y1_use_ye = 1'b1;
                  y_add_th  = 1'b1;
               end
            endcase
         end
         default: begin
         end
      endcase

      x0_sel = x0_use_xe ? xe_ff : xs_ff;
      y0_sel = y0_use_ye ? ye_ff : ys_ff;
      x1_raw = {1'b0, (x1_use_xe ? xe_ff : xs_ff)}
             + (x_add_th ? (CW + 1)'(th_ff) : '0);
      y1_raw = {1'b0, (y1_use_ye ? ye_ff : ys_ff)}
             + (y_add_th ? (CW + 1)'(th_ff) : '0);
      x1_clip = (x1_raw >= X_LIM) ? X_MAX : x1_raw[CW-1:0];
      y1_clip = (y1_raw >= Y_LIM) ? Y_MAX : y1_raw[CW-1:0];
   end

   assign pix_sum   = CALC_W'(base_ff) + CALC_W'(cx_ff[CW-1:1]);
   assign pix_addr  = pix_sum[ADDR_W-1:0];
   assign base_mul  = CALC_W'(y0_ff) * CALC_W'(ROW_BYTES);
   assign base_step = CALC_W'(base_ff) + CALC_W'(ROW_BYTES);

   assign last_rect  = (op_ff != pnrd_pkg::OP_BOX) || (phase_ff == pnrd_pkg::PH_RIGHT);
   assign after_rect = last_rect ? pnrd_pkg::ST_FIN : pnrd_pkg::ST_SETUP;

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      op_in       = op_ff;
      xs_in       = xs_ff;
      ys_in       = ys_ff;
      xe_in       = xe_ff;
      ye_in       = ye_ff;
      color_in    = color_ff;
      th_in       = th_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      y0_in       = y0_ff;
      y1_in       = y1_ff;
      empty_in    = empty_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      base_in     = base_ff;
      clr_addr_in = clr_addr_ff;
      rd_nib_in   = rd_nib_ff;
      mem_ctl     = '0;
      mem_addr    = pix_addr;
      mem_wr_data = cx_ff[0] ? {mem_rd_data[7:4], color_ff} : {color_ff, mem_rd_data[3:0]};

      case (state_ff)
         pnrd_pkg::ST_IDLE: begin
            phase_in = pnrd_pkg::PH_TOP;
            if (ctl.start) begin
               op_in     = opcode;
               xs_in     = x_start;
               ys_in     = y_start;
               xe_in     = x_end;
               ye_in     = y_end;
               color_in  = color;
               th_in     = thickness;
               rd_nib_in = '0;
               state_in  = pnrd_pkg::ST_SETUP;
            end
         end
         pnrd_pkg::ST_SETUP: begin
            case (op_ff)
               pnrd_pkg::OP_CLEAR: begin
                  clr_addr_in = '0;
                  state_in    = pnrd_pkg::ST_CLEAR;
               end
               pnrd_pkg::OP_WRITE, pnrd_pkg::OP_READ, pnrd_pkg::OP_HLINE,
               pnrd_pkg::OP_VLINE, pnrd_pkg::OP_BOX: begin
                  x0_in    = x0_sel;
                  x1_in    = x1_clip;
                  y0_in    = y0_sel;
                  y1_in    = y1_clip;
                  empty_in = (x0_sel > x1_clip) || (y0_sel > y1_clip);
                  state_in = pnrd_pkg::ST_BASE;
               end
               default: begin
                  state_in = pnrd_pkg::ST_FIN;
               end
            endcase
         end
         pnrd_pkg::ST_BASE: begin
            if (empty_ff) begin
               phase_in = last_rect ? pnrd_pkg::PH_TOP : phase_ff + 1'b1;
               state_in = after_rect;
            end else begin
               base_in  = base_mul[ADDR_W-1:0];
               cx_in    = x0_ff;
               cy_in    = y0_ff;
               state_in = pnrd_pkg::ST_RD;
            end
         end
         pnrd_pkg::ST_RD: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = pnrd_pkg::ST_WR;
         end
         pnrd_pkg::ST_WR: begin
            if (op_ff == pnrd_pkg::OP_READ) begin
               rd_nib_in = cx_ff[0] ? mem_rd_data[3:0] : mem_rd_data[7:4];
            end else begin
               mem_ctl.wr_en = 1'b1;
            end
            if (cx_ff != x1_ff) begin
               cx_in    = cx_ff + 1'b1;
               state_in = pnrd_pkg::ST_RD;
            end else if (cy_ff != y1_ff) begin
               cx_in    = x0_ff;
               cy_in    = cy_ff + 1'b1;
               base_in  = base_step[ADDR_W-1:0];
               state_in = pnrd_pkg::ST_RD;
            end else begin
               phase_in = last_rect ? pnrd_pkg::PH_TOP : phase_ff + 1'b1;
               state_in = after_rect;
            end
         end
         pnrd_pkg::ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr      = clr_addr_ff;
            mem_wr_data   = clear_byte;
            clr_addr_in   = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = pnrd_pkg::ST_FIN;
            end
         end
         pnrd_pkg::ST_FIN: begin
            phase_in = pnrd_pkg::PH_TOP;
            if (ctl.ack) begin
               state_in = pnrd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pnrd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pnrd_pkg::ST_IDLE;
         phase_ff <= pnrd_pkg::PH_TOP;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      xs_ff       <= xs_in;
      ys_ff       <= ys_in;
      xe_ff       <= xe_in;
      ye_ff       <= ye_in;
      color_ff    <= color_in;
      th_ff       <= th_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      empty_ff    <= empty_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      base_ff     <= base_in;
      clr_addr_ff <= clr_addr_in;
      rd_nib_ff   <= rd_nib_in;
   end

   assign stat.idle  = (state_ff == pnrd_pkg::ST_IDLE);
   assign stat.done  = (state_ff == pnrd_pkg::ST_FIN);
   assign read_pixel = rd_nib_ff;

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pnrd_pkg::ST_WR) |-> ($past(state_ff) == pnrd_pkg::ST_RD))
      else $error("pixel write without preceding read");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == pnrd_pkg::ST_IDLE) |-> (phase_ff == pnrd_pkg::PH_TOP))
      else $error("box edge left set while idle");
   assert property (@(posedge clock) disable iff (reset)
      (ctl.start && state_ff == pnrd_pkg::ST_IDLE) |=> (state_ff == pnrd_pkg::ST_SETUP))
      else $error("accepted item not started");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != pnrd_pkg::PH_TOP) |-> (op_ff == pnrd_pkg::OP_BOX))
      else $error("box edge advanced on a non-box command");
`endif

endmodule

[tb/sv/pnrd_frame_checker.sv]
// ----------------------------------------------------------------------------
// pnrd_frame_checker: scoreboard for the packed nibble rectangle drawer
// Keeps a byte image of the 4bpp framebuffer and a copy of clear_byte, works
// out each command's result when the command is accepted, and compares the
// result items in order as they leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pnrd_frame_checker #(
   parameter int FB_WIDTH  = 320,
   parameter int FB_HEIGHT = 240
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [pnrd_pkg::OP_W-1:0]    req_opcode,
   input  logic [pnrd_pkg::COORD_W-1:0] req_x_start,
   input  logic [pnrd_pkg::COORD_W-1:0] req_y_start,
   input  logic [pnrd_pkg::COORD_W-1:0] req_x_end,
   input  logic [pnrd_pkg::COORD_W-1:0] req_y_end,
   input  logic [pnrd_pkg::COLOR_W-1:0] req_color,
   input  logic [pnrd_pkg::TH_W-1:0]    req_thickness,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [pnrd_pkg::COLOR_W-1:0] rsp_read_pixel,
   input  logic                         rsp_done_res,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [pnrd_pkg::BYTE_W-1:0]  csr_clear_byte,
   output int                           fail_count,
   output int                           pending_count
);

   localparam int ROW_BYTES   = (FB_WIDTH + 1) / 2;
   localparam int STORE_BYTES = ROW_BYTES * FB_HEIGHT;
   localparam int MAX_REPORTS = 10;

   logic [pnrd_pkg::BYTE_W-1:0]  frame_bytes [STORE_BYTES];
   logic [pnrd_pkg::BYTE_W-1:0]  clear_value;
   logic [pnrd_pkg::COLOR_W-1:0] expected_read_pixels [$];

   // even x lives in the high nibble
   function automatic void plot_pixel(int x, int y, logic [pnrd_pkg::COLOR_W-1:0] color);
      int idx;
      if (x >= FB_WIDTH || y >= FB_HEIGHT) return;
      idx = y * ROW_BYTES + x / 2;
      if (x % 2 == 1) frame_bytes[idx][3:0] = color;
      else frame_bytes[idx][7:4] = color;
   endfunction

   function automatic logic [pnrd_pkg::COLOR_W-1:0] fetch_pixel(int x, int y);
      int idx;
      if (x >= FB_WIDTH || y >= FB_HEIGHT) return '0;
      idx = y * ROW_BYTES + x / 2;
      return (x % 2 == 1) ? frame_bytes[idx][3:0] : frame_bytes[idx][7:4];
   endfunction

   // inclusive corners, far side clipped; start past end draws nothing
   function automatic void paint_rect(int x0, int x1, int y0, int y1,
                                      logic [pnrd_pkg::COLOR_W-1:0] color);
      if (x1 >= FB_WIDTH) x1 = FB_WIDTH - 1;
      if (y1 >= FB_HEIGHT) y1 = FB_HEIGHT - 1;
      for (int y = y0; y <= y1; y++)
         for (int x = x0; x <= x1; x++)
            plot_pixel(x, y, color);
   endfunction

   function automatic logic [pnrd_pkg::COLOR_W-1:0] run_command(
      logic [pnrd_pkg::OP_W-1:0] op, int xs, int ys, int xe, int ye,
      logic [pnrd_pkg::COLOR_W-1:0] color, int th);
      logic [pnrd_pkg::COLOR_W-1:0] pixel;
      pixel = '0;
      case (op)
         pnrd_pkg::OP_WRITE: plot_pixel(xs, ys, color);
         pnrd_pkg::OP_READ:  pixel = fetch_pixel(xs, ys);
         pnrd_pkg::OP_HLINE: paint_rect(xs, xe, ys, ys + th, color);
         pnrd_pkg::OP_VLINE: paint_rect(xs, xs + th, ys, ye, color);
         pnrd_pkg::OP_BOX: begin
            paint_rect(xs, xe, ys, ys + th, color);
            paint_rect(xs, xe, ye, ye + th, color);
            paint_rect(xs, xs + th, ys, ye, color);
            paint_rect(xe, xe + th, ys, ye + th, color);   // right edge runs long
         end
         pnrd_pkg::OP_CLEAR: begin
            foreach (frame_bytes[i]) frame_bytes[i] = clear_value;
         end
         default: ;
      endcase
      return pixel;
   endfunction

   task automatic log_failure(input string what);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
   endtask

   always @(posedge clock) begin : monitor
      logic [pnrd_pkg::COLOR_W-1:0] want;
      if (reset) begin
         clear_value = '0;
         expected_read_pixels.delete();
         fail_count = 0;
         pending_count = 0;
      end else begin
         if (csr_valid && csr_ready) clear_value = csr_clear_byte;

         if (rsp_valid && !rsp_stall) begin
            if (expected_read_pixels.size() == 0) begin
               log_failure($sformatf("result with none pending (read_pixel %0h done_res %0b)",
                                     rsp_read_pixel, rsp_done_res));
            end else begin
               want = expected_read_pixels.pop_front();
               if (rsp_read_pixel !== want)
                  log_failure($sformatf("read_pixel expected %0h got %0h",
                                        want, rsp_read_pixel));
               if (rsp_done_res !== 1'b1)
                  log_failure($sformatf("done_res expected 1 got %0b", rsp_done_res));
            end
         end

         if (req_valid && !req_stall)
            expected_read_pixels.push_back(run_command(
               req_opcode, int'(req_x_start), int'(req_y_start), int'(req_x_end),
               int'(req_y_end), req_color, int'(req_thickness)));

         pending_count = expected_read_pixels.size();
      end
   end

endmodule

[tb/sv/tb_packed_nibble_rect_drawer.sv]
// ----------------------------------------------------------------------------
// tb_packed_nibble_rect_drawer: top level for the rectangle drawer bench
// Drives directed and random drawing commands through the item handshake,
// with idle and stall patterns on both sides, rewrites clear_byte between
// phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packed_nibble_rect_drawer;

   localparam int FB_WIDTH  = 320;
   localparam int FB_HEIGHT = 240;

   // opcodes the block ignores; they still return one item
   localparam logic [pnrd_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [pnrd_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

   localparam int RANDOM_PER_PHASE = 370;
   localparam int NUM_PHASES       = 4;
   localparam int RSP_HOLD_CYCLES  = 3000;
   // a clear walks all 38400 bytes
   localparam int WATCHDOG_LIMIT   = 200000;
   localparam int END_DRAIN_CYCLES = 16;

   typedef struct packed {
      logic [pnrd_pkg::OP_W-1:0]    opcode;
      logic [pnrd_pkg::COORD_W-1:0] x_start;
      logic [pnrd_pkg::COORD_W-1:0] y_start;
      logic [pnrd_pkg::COORD_W-1:0] x_end;
      logic [pnrd_pkg::COORD_W-1:0] y_end;
      logic [pnrd_pkg::COLOR_W-1:0] color;
      logic [pnrd_pkg::TH_W-1:0]    thickness;
   } draw_cmd_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [pnrd_pkg::OP_W-1:0]    req_opcode;
   logic [pnrd_pkg::COORD_W-1:0] req_x_start;
   logic [pnrd_pkg::COORD_W-1:0] req_y_start;
   logic [pnrd_pkg::COORD_W-1:0] req_x_end;
   logic [pnrd_pkg::COORD_W-1:0] req_y_end;
   logic [pnrd_pkg::COLOR_W-1:0] req_color;
   logic [pnrd_pkg::TH_W-1:0]    req_thickness;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [pnrd_pkg::COLOR_W-1:0] rsp_read_pixel;
   logic                         rsp_done_res;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [pnrd_pkg::BYTE_W-1:0]  csr_clear_byte;

   int fail_count;
   int pending_count;

   // idle percentages per phase: none, sender only, receiver only, both
   int send_idle_by_phase [NUM_PHASES] = '{0, 69, 0, 11};
   int rsp_stall_by_phase [NUM_PHASES] = '{0, 0, 69, 11};
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit hold_rsp = 1'b0;

   // last drawn spot, so reads and writes land next to fresh pixels
   logic [pnrd_pkg::COORD_W-1:0] last_x = '0;
   logic [pnrd_pkg::COORD_W-1:0] last_y = '0;

   packed_nibble_rect_drawer #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_color      (req_color),
      .req_thickness  (req_thickness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_pixel (rsp_read_pixel),
      .rsp_done_res   (rsp_done_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_clear_byte (csr_clear_byte)
   );

   pnrd_frame_checker #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_color      (req_color),
      .req_thickness  (req_thickness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_pixel (rsp_read_pixel),
      .rsp_done_res   (rsp_done_res),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_clear_byte (csr_clear_byte),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver side. Normally a per-cycle coin toss; on request it holds off
   // for a long fixed stretch so the block backs up and stalls its input.
   initial begin : rsp_stall_gen
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // Watchdog: any cycle with a handshake on any channel resets the count.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Present one command and hold it until the block takes it. Valid is left
   // high so a back-to-back item needs only one assignment per edge.
   task automatic send_cmd(input logic [pnrd_pkg::OP_W-1:0] op,
                           input logic [pnrd_pkg::COORD_W-1:0] xs,
                           input logic [pnrd_pkg::COORD_W-1:0] ys,
                           input logic [pnrd_pkg::COORD_W-1:0] xe,
                           input logic [pnrd_pkg::COORD_W-1:0] ye,
                           input logic [pnrd_pkg::COLOR_W-1:0] color,
                           input logic [pnrd_pkg::TH_W-1:0] th);
      req_opcode    <= op;
      req_x_start   <= xs;
      req_y_start   <= ys;
      req_x_end     <= xe;
      req_y_end     <= ye;
      req_color     <= color;
      req_thickness <= th;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Random gap after an item; lengths reach well into a command's run time
   // so gaps land on every part of the block's work.
   task automatic sender_gap();
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected item has come back.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_clear_byte(input logic [pnrd_pkg::BYTE_W-1:0] value);
      csr_clear_byte <= value;
      csr_valid      <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid      <= 1'b0;
   endtask

   // mostly on screen or just past its edge, sometimes anywhere in 10 bits
   function automatic logic [pnrd_pkg::COORD_W-1:0] pick_coord(int lim);
      if ($urandom_range(0, 3) != 0) return pnrd_pkg::COORD_W'($urandom_range(0, lim + 2));
      return pnrd_pkg::COORD_W'($urandom_range(0, 1023));
   endfunction

   // Short spans by default; sometimes an empty (reversed) range; sometimes a
   // full random end unless the caller needs a narrow span to bound run time.
   function automatic logic [pnrd_pkg::COORD_W-1:0] pick_end(
      logic [pnrd_pkg::COORD_W-1:0] start, bit narrow);
      int roll;
      int stop;
      roll = $urandom_range(0, 99);
      if (!narrow && roll < 10) return pnrd_pkg::COORD_W'($urandom_range(0, 1023));
      if (roll < 18 && start != 0) begin
         stop = int'(start) - int'($urandom_range(1, 3));
         return pnrd_pkg::COORD_W'((stop < 0) ? 0 : stop);
      end
      stop = int'(start) + int'($urandom_range(0, 12));
      return pnrd_pkg::COORD_W'((stop > 1023) ? 1023 : stop);
   endfunction

   task automatic send_random_cmd();
      draw_cmd_type cmd;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 22)      cmd.opcode = pnrd_pkg::OP_WRITE;
      else if (roll < 44) cmd.opcode = pnrd_pkg::OP_READ;
      else if (roll < 60) cmd.opcode = pnrd_pkg::OP_HLINE;
      else if (roll < 76) cmd.opcode = pnrd_pkg::OP_VLINE;
      else if (roll < 92) cmd.opcode = pnrd_pkg::OP_BOX;
      else if (roll < 96) cmd.opcode = OP_SPARE6;
      else                cmd.opcode = OP_SPARE7;

      cmd.color   = pnrd_pkg::COLOR_W'($urandom_range(0, 15));
      cmd.x_start = pick_coord(FB_WIDTH);
      cmd.y_start = pick_coord(FB_HEIGHT);

      // thick strokes are rare; a box's long right edge grows with the square
      // of the thickness, so boxes stay thin
      if ($urandom_range(0, 99) < 15) cmd.thickness = pnrd_pkg::TH_W'($urandom_range(0, 255));
      else cmd.thickness = pnrd_pkg::TH_W'($urandom_range(0, 3));
      if (cmd.opcode == pnrd_pkg::OP_BOX && cmd.thickness > 7)
         cmd.thickness = pnrd_pkg::TH_W'($urandom_range(0, 7));

      cmd.x_end = pick_end(cmd.x_start,
                           cmd.opcode == pnrd_pkg::OP_HLINE && cmd.thickness > 3);
      cmd.y_end = pick_end(cmd.y_start,
                           cmd.opcode == pnrd_pkg::OP_VLINE && cmd.thickness > 3);

      // half of the pixel accesses hit the last drawn spot or its byte partner
      if ((cmd.opcode == pnrd_pkg::OP_READ || cmd.opcode == pnrd_pkg::OP_WRITE) &&
          $urandom_range(0, 1)) begin
         cmd.x_start = (cmd.opcode == pnrd_pkg::OP_WRITE) ? (last_x ^ 10'd1) : last_x;
         cmd.y_start = last_y;
      end
      if (cmd.opcode != pnrd_pkg::OP_READ && cmd.x_start < FB_WIDTH &&
          cmd.y_start < FB_HEIGHT) begin
         last_x = cmd.x_start;
         last_y = cmd.y_start;
      end

      send_cmd(cmd.opcode, cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end,
               cmd.color, cmd.thickness);
   endtask

   initial begin : stimulus
      req_valid      <= 1'b0;
      req_opcode     <= pnrd_pkg::OP_WRITE;
      req_x_start    <= '0;
      req_y_start    <= '0;
      req_x_end      <= '0;
      req_y_end      <= '0;
      req_color      <= '0;
      req_thickness  <= '0;
      csr_valid      <= 1'b0;
      csr_clear_byte <= '0;
      reset          <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // The framebuffer is undefined until written, so the very first command
      // is a clear; every later read then sees known data.
      write_clear_byte(8'hFF);
      send_cmd(pnrd_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);
      send_cmd(pnrd_pkg::OP_READ, 319, 239, 0, 0, 0, 0);
      // both nibbles of one byte
      send_cmd(pnrd_pkg::OP_WRITE, 0, 0, 0, 0, 4'h0, 0);
      send_cmd(pnrd_pkg::OP_WRITE, 1, 0, 0, 0, 4'hA, 0);
      send_cmd(pnrd_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
      send_cmd(pnrd_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
      // far corner, then its even neighbor
      send_cmd(pnrd_pkg::OP_WRITE, 319, 239, 0, 0, 4'h5, 0);
      send_cmd(pnrd_pkg::OP_READ, 318, 239, 0, 0, 0, 0);
      // off screen write is dropped, off screen reads return zero
      send_cmd(pnrd_pkg::OP_WRITE, 1023, 1023, 1023, 1023, 4'hF, 8'hFF);
      send_cmd(pnrd_pkg::OP_READ, 320, 0, 0, 0, 0, 0);
      send_cmd(pnrd_pkg::OP_READ, 0, 240, 0, 0, 0, 0);
      send_cmd(pnrd_pkg::OP_READ, 1023, 1023, 0, 0, 0, 0);
      // full row with the right end clipped
      send_cmd(pnrd_pkg::OP_HLINE, 0, 5, 1023, 0, 4'h3, 0);
      // maximum thickness runs past the bottom edge
      send_cmd(pnrd_pkg::OP_HLINE, 10, 0, 11, 1023, 4'hC, 8'hFF);
      send_cmd(pnrd_pkg::OP_VLINE, 318, 0, 0, 1023, 4'h6, 8'hFF);
      // reversed ranges draw nothing, then a thin box
      send_cmd(pnrd_pkg::OP_HLINE, 50, 7, 40, 0, 4'h1, 2);
      send_cmd(pnrd_pkg::OP_VLINE, 60, 30, 0, 20, 4'h1, 2);
      send_cmd(pnrd_pkg::OP_BOX, 20, 20, 40, 30, 4'h9, 1);
      // thick box in the lower right corner, every edge clipped
      send_cmd(pnrd_pkg::OP_BOX, 300, 200, 310, 230, 4'hE, 8'hFF);
      send_cmd(pnrd_pkg::OP_BOX, 100, 100, 90, 110, 4'h2, 0);
      send_cmd(OP_SPARE6, 1023, 1023, 1023, 1023, 4'hF, 8'hFF);
      send_cmd(OP_SPARE7, 0, 0, 0, 0, 0, 0);
      send_cmd(pnrd_pkg::OP_READ, 310, 235, 0, 0, 0, 0);
      send_cmd(pnrd_pkg::OP_READ, 21, 20, 0, 0, 0, 0);

      // ---- random phases ----
      // Each phase starts idle: new clear_byte (zero in the first), then a
      // clear so the value shows up in later reads.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_results_drained();
         send_idle_pct = send_idle_by_phase[phase];
         rsp_stall_pct = rsp_stall_by_phase[phase];
         if (phase == 0) write_clear_byte(8'h00);
         else write_clear_byte(pnrd_pkg::BYTE_W'($urandom_range(0, 255)));
         send_cmd(pnrd_pkg::OP_CLEAR, pick_coord(FB_WIDTH), pick_coord(FB_HEIGHT),
                  pick_coord(FB_WIDTH), pick_coord(FB_HEIGHT), 0, 0);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n == RANDOM_PER_PHASE / 2) begin
               // no idling in phase 0: receiver holds off while items keep coming
               if (phase == 0) hold_rsp = 1'b1;
               // sender pause until the block has emptied
               if (phase == 1) wait_results_drained();
            end
            send_random_cmd();
            sender_gap();
         end
      end

      wait_results_drained();
      repeat (END_DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/pnrd_pkg.sv
hw/rtl/pnrd_fb_mem.sv
hw/rtl/pnrd_seq.sv
hw/rtl/packed_nibble_rect_drawer.sv
tb/sv/pnrd_frame_checker.sv
tb/sv/tb_packed_nibble_rect_drawer.sv
